@@ hdl/lrupr_pkg.sv @@
`timescale 1ns / 1ps

package lrupr_pkg;

  // Fixed port widths
  localparam int PAGE_W  = 16;  // page number on the ports
  localparam int FRAME_W = 4;   // reported frame index
  localparam int CFG_W   = 5;   // frames_in_use register
  localparam int COUNT_W = 32;  // fault / reference totals

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

  // One finished lookup, engine to output stage
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
  } result_t;

endpackage

@@ hdl/lrupr_ram.sv @@
`timescale 1ns / 1ps

module lrupr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/lrupr_engine.sv @@
`timescale 1ns / 1ps

module lrupr_engine #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [lrupr_pkg::PAGE_W-1:0]  req_page,
  output logic                          res_valid,
  input  logic                          res_ready,
  output lrupr_pkg::result_t            res
);

  import lrupr_pkg::*;

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int WORD_W = PAGE_BITS + RANK_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_TOUCH  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]           state;
  logic [CFG_W-1:0]     frames_cfg;
  logic [CNT_W-1:0]     n_active;
  logic [FRAMES-1:0]    valid;
  logic [IDX_W-1:0]     fill_pointer;
  logic [CNT_W-1:0]     cnt;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;
  logic [PAGE_BITS-1:0] page_key;

  // scan results
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic [RANK_W-1:0]    hit_rank;
  logic                 found;
  logic [RANK_W-1:0]    best_rank;
  logic [IDX_W-1:0]     vic_idx;
  logic [PAGE_BITS-1:0] vic_page;

  // decision
  logic [IDX_W-1:0]     tgt_idx;
  logic                 age_all;
  logic [RANK_W-1:0]    limit;
  logic                 ev;

  // memory ports
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [WORD_W-1:0]    mem_rdata;
  logic                 mem_we;
  logic [IDX_W-1:0]     wr_addr;
  logic [PAGE_BITS-1:0] wr_page;
  logic [RANK_W-1:0]    wr_rank;
  logic [PAGE_BITS-1:0] rd_page;
  logic [RANK_W-1:0]    rd_rank;

  logic                 fill_ok;
  logic [CNT_W-1:0]     fp_inc;
  logic [IDX_W-1:0]     fp_next;

  // out-of-range frame counts clamp to 1..FRAMES
  always_comb begin
    if (frames_cfg == '0) begin
      n_active = CNT_W'(1);
    end else if (int'(frames_cfg) > FRAMES) begin
      n_active = CNT_W'(FRAMES);
    end else begin
      n_active = CNT_W'(frames_cfg);
    end
  end

  assign rd_page = mem_rdata[WORD_W-1:RANK_W];
  assign rd_rank = mem_rdata[RANK_W-1:0];

  assign mem_re    = ((state == S_SCAN) || (state == S_TOUCH)) && (cnt < n_active);
  assign mem_raddr = cnt[IDX_W-1:0];

  // write-back: target becomes newest, younger valid frames age by one
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = rd_idx;
    wr_page = page_key;
    wr_rank = '0;
    if ((state == S_TOUCH) && rd_vld) begin
      if (rd_idx == tgt_idx) begin
        mem_we = 1'b1;
      end else if (valid[rd_idx] && (age_all || (rd_rank < limit))) begin
        mem_we  = 1'b1;
        wr_page = rd_page;
        wr_rank = RANK_W'(rd_rank + 1'b1);
      end
    end
  end

  assign fill_ok = (CNT_W'(fill_pointer) < n_active) && !valid[fill_pointer];
  assign fp_inc  = CNT_W'(fill_pointer) + CNT_W'(1);
  assign fp_next = (fp_inc >= n_active) ? '0 : IDX_W'(fp_inc);

  lrupr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata ({wr_page, wr_rank}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.hit      = hit_found;
    res.frame    = FRAME_W'(tgt_idx);
    res.ev_valid = ev;
    res.ev_page  = ev ? PAGE_W'(vic_page) : '0;
  end

  always_ff @(posedge clk) begin
    rd_vld <= mem_re;
    rd_idx <= mem_raddr;
    if (mem_re) begin
      cnt <= cnt + CNT_W'(1);
    end

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          page_key  <= PAGE_BITS'(req_page);
          hit_found <= 1'b0;
          found     <= 1'b0;
          cnt       <= '0;
          state     <= S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_vld && valid[rd_idx]) begin
          if (!hit_found && (rd_page == page_key)) begin
            hit_found <= 1'b1;
            hit_idx   <= rd_idx;
            hit_rank  <= rd_rank;
          end
          // strict compare keeps the lowest index on a tie
          if (!found || (rd_rank > best_rank)) begin
            found     <= 1'b1;
            best_rank <= rd_rank;
            vic_idx   <= rd_idx;
            vic_page  <= rd_page;
          end
        end
        if (rd_vld && (cnt == n_active)) begin
          state <= S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (hit_found) begin
          tgt_idx <= hit_idx;
          age_all <= 1'b0;
          limit   <= hit_rank;
          ev      <= 1'b0;
        end else if (fill_ok) begin
          tgt_idx             <= fill_pointer;
          fill_pointer        <= fp_next;
          valid[fill_pointer] <= 1'b1;
          age_all             <= 1'b1;
          ev                  <= 1'b0;
        end else begin
          tgt_idx        <= vic_idx;
          valid[vic_idx] <= 1'b1;
          age_all        <= 1'b1;
          ev             <= found;
        end
        cnt   <= '0;
        state <= S_TOUCH;
      end
      S_TOUCH: begin
        if (rd_vld && (cnt == n_active)) begin
          state <= S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state <= S_IDLE;
        end
      end
      default: begin
        state <= S_IDLE;
      end
    endcase

    // new frame count empties the table
    if (cfg_we) begin
      frames_cfg   <= cfg_wdata;
      valid        <= '0;
      fill_pointer <= '0;
    end

    if (rst) begin
      state        <= S_IDLE;
      frames_cfg   <= FRAMES_RESET;
      valid        <= '0;
      fill_pointer <= '0;
      cnt          <= '0;
      rd_vld       <= 1'b0;
      hit_found    <= 1'b0;
      found        <= 1'b0;
      ev           <= 1'b0;
      age_all      <= 1'b0;
    end
  end

`ifndef SYNTH
  // read and write-back never touch the same entry in one cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (wr_addr != mem_raddr))
    else $error("table read and write hit the same entry");

  // a hit can only come from a valid frame, so a victim candidate exists
  a_hit_has_candidate: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DECIDE) && hit_found) |-> found)
    else $error("hit without any valid frame seen");

  // the chosen frame is resident once the decision is made
  a_target_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DECIDE) && !cfg_we) |=> valid[tgt_idx])
    else $error("target frame not marked valid");
`endif

endmodule

@@ hdl/lrupr_out.sv @@
`timescale 1ns / 1ps

module lrupr_out (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           res_valid,
  output logic                           res_ready,
  input  lrupr_pkg::result_t             res,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic                           hit,
  output logic [lrupr_pkg::FRAME_W-1:0]  frame_index,
  output logic                           evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]   evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0]  fault_total,
  output logic [lrupr_pkg::COUNT_W-1:0]  reference_total
);

  import lrupr_pkg::*;

  logic [COUNT_W-1:0] fault_count;
  logic [COUNT_W-1:0] reference_count;
  logic [COUNT_W-1:0] fault_count_next;
  logic [COUNT_W-1:0] reference_count_next;
  logic               load;

  assign res_ready = !rsp_valid || rsp_ready;
  assign load      = res_valid && res_ready;

  // saturating counts
  always_comb begin
    reference_count_next = (reference_count == '1) ? reference_count
                                                   : reference_count + COUNT_W'(1);
    fault_count_next = fault_count;
    if (!res.hit && (fault_count != '1)) begin
      fault_count_next = fault_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fault_count     <= fault_count_next;
      reference_count <= reference_count_next;
      hit             <= res.hit;
      frame_index     <= res.frame;
      evicted_valid   <= res.ev_valid;
      evicted_page    <= res.ev_page;
      fault_total     <= fault_count_next;
      reference_total <= reference_count_next;
      rsp_valid       <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (rst) begin
      fault_count     <= '0;
      reference_count <= '0;
      rsp_valid       <= 1'b0;
    end
  end

`ifndef SYNTH
  // every fault is also a reference
  a_faults_le_refs: assert property (@(posedge clk) disable iff (rst)
    fault_count <= reference_count)
    else $error("fault count exceeds reference count");
`endif

endmodule

@@ hdl/lru_page_replacement.sv @@
`timescale 1ns / 1ps

// LRU page replacement table.
// Request channel (req_valid/req_ready, page_number): one page reference per
// transfer. Response channel (rsp_valid/rsp_ready): one result per reference
// with hit, frame_index, evicted_valid/evicted_page and saturating 32-bit
// fault_total and reference_total.
// Config channel (cfg_valid/cfg_ready, cfg_data): writes frames_in_use
// (0 acts as 1, values above FRAMES act as FRAMES) and empties the table;
// counts are kept. Write it only while no reference is in flight.
// Table: with n managed frames the table lives in one RAM with a single read
// and a single write port: one pass reads all n entries to find a hit or the
// oldest frame, a second pass reads them again and writes back aged ranks.
// A new reference is taken only once the last result has left the engine.
// Reset: table empty, frames_in_use = 16, both counts zero; no clearing pass
// is needed since valid bits are flops.
// Stall: the result waits in the output register while rsp_ready is low;
// the next reference is already taken and worked on, and its result waits
// in the engine until the output register frees up.
module lru_page_replacement #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]    cfg_data,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [lrupr_pkg::PAGE_W-1:0]   page_number,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic                           hit,
  output logic [lrupr_pkg::FRAME_W-1:0]  frame_index,
  output logic                           evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]   evicted_page,
  output logic [lrupr_pkg::COUNT_W-1:0]  fault_total,
  output logic [lrupr_pkg::COUNT_W-1:0]  reference_total
);

  import lrupr_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;

  // config is always taken; it is only legal between references
  assign cfg_ready = 1'b1;

  lrupr_engine #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_wdata (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_page  (page_number),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register and running counts
  lrupr_out u_out (
    .clk             (clk),
    .rst             (rst),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .hit             (hit),
    .frame_index     (frame_index),
    .evicted_valid   (evicted_valid),
    .evicted_page    (evicted_page),
    .fault_total     (fault_total),
    .reference_total (reference_total)
  );

endmodule
